/* src/postfix_integer_evaluator_assert.svh */
// Assertion macros shared by the evaluator's checker.
// Depends on nothing; included by the checker file.
`ifndef POSTFIX_INTEGER_EVALUATOR_ASSERT_SVH
`define POSTFIX_INTEGER_EVALUATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PIE_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PIE_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/pie_pkg.sv */
// Package for the postfix integer evaluator: constants, codes and command types.
// Depends on nothing; used by the evaluator top level, controller, datapath and testbench.
package pie_pkg;
  localparam int STACK_DEPTH_DEF = 64;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;   // latch the request character
    logic       digit;     // fold the digit into the accumulator
    logic       flush;     // push accumulator if a number is open
    logic       rd_ops;    // read top two entries
    logic       exec;      // start arithmetic on read operands
    logic       wr_res;    // pop two, push result
    logic       rd_top;    // read top for the report
    logic       report;    // load output register, clear expression state
  } pie_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       err;       // an error is held
    logic       ge2;       // at least two entries
    logic       rzero;     // right operand is zero
    logic       div_done;  // divider finished
    logic [1:0] op;        // operator code of captured character
    logic       is_op;     // captured character is an operator
    logic       is_digit;  // captured character is a digit
    logic       last;      // captured last flag
  } pie_sts_t;
endpackage

/* src/postfix_integer_evaluator.sv */
// Postfix integer evaluator: takes one ASCII character per request and reports
// the top-of-stack result on the character flagged tlast. A digit or a skipped
// character is decoded and done; + and - read both operands and write back,
// * also waits on the registered multiplier, and / on the one-bit-per-cycle
// restoring divider. The last character then pushes any open number, reads the
// top and reports, after any wait for the output register to empty. A finished
// report waits in the output register while the next request is taken.
module postfix_integer_evaluator #(
  parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [33:32] status, zero fill
);
  pie_pkg::pie_cmd_t cmd;
  pie_pkg::pie_sts_t sts;
  logic [31:0] res_value;
  logic [1:0]  res_status;

  pie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  pie_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_ch(in_tdata), .in_last(in_tlast), .cmd(cmd),
    .sts(sts), .res_value(res_value), .res_status(res_status)
  );

  assign out_tdata = {6'd0, res_status, res_value};
endmodule

/* src/pie_div.sv */
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
// Depends on nothing beyond its ports.
module pie_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem_r, rem_nxt, q_r, q_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [32:0] trial;

  assign trial = {rem_r, q_r[31]} - {1'b0, d_r};

  // Iteration: shift one numerator bit into the remainder per cycle.
  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      q_nxt = num[31] ? (32'd0 - num) : num;
      d_nxt = den[31] ? (32'd0 - den) : den;
      neg_nxt = num[31] ^ den[31];
      cnt_nxt = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? (32'd0 - q_r) : q_r;
endmodule

/* src/pie_datapath.sv */
// Evaluator datapath: operand stack memory, number accumulator, ALU, divider.
// Depends on pie_pkg and pie_div.
module pie_datapath #(
  parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_ch,
  input  logic              in_last,
  input  pie_pkg::pie_cmd_t cmd,
  output pie_pkg::pie_sts_t sts,
  output logic [31:0]       res_value,
  output logic [1:0]        res_status
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [31:0]   mem [STACK_DEPTH];
  logic [7:0]    ch_r;
  logic          last_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          innum_r, innum_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [31:0]   rd_r, l_r, r_r, prod_r;
  logic          rd_sel_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;
  logic          rd_en;
  logic [1:0]    op_code;
  logic          div_start, div_done;
  logic [31:0]   div_q, alu;
  logic [31:0]   acc_x10;

  // Character decode.
  always_comb begin
    unique case (ch_r)
      pie_pkg::CH_ADD: op_code = pie_pkg::OP_ADD;
      pie_pkg::CH_SUB: op_code = pie_pkg::OP_SUB;
      pie_pkg::CH_MUL: op_code = pie_pkg::OP_MUL;
      default:         op_code = pie_pkg::OP_DIV;
    endcase
  end

  assign sts.err      = (err_r != pie_pkg::ST_OK);
  assign sts.ge2      = (cnt_r >= CW'(2));
  assign sts.rzero    = (r_r == 32'd0);
  assign sts.div_done = div_done;
  assign sts.op       = op_code;
  assign sts.is_op    = (ch_r == pie_pkg::CH_ADD) || (ch_r == pie_pkg::CH_SUB) ||
                        (ch_r == pie_pkg::CH_MUL) || (ch_r == pie_pkg::CH_DIV);
  assign sts.is_digit = (ch_r >= pie_pkg::CH_ZERO) && (ch_r <= pie_pkg::CH_NINE);
  assign sts.last     = last_r;

  assign acc_x10 = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};

  // Stack and accumulator control.
  always_comb begin
    cnt_nxt = cnt_r; acc_nxt = acc_r; innum_nxt = innum_r; err_nxt = err_r;
    mem_we = 1'b0; mem_wa = cnt_r[AW-1:0]; mem_wd = acc_r;
    if (cmd.digit && err_r == pie_pkg::ST_OK) begin
      acc_nxt = acc_x10 + {28'd0, ch_r[3:0]};
      innum_nxt = 1'b1;
    end
    if (cmd.flush && innum_r) begin
      if (err_r == pie_pkg::ST_OK) begin
        if (cnt_r == FULL) begin
          err_nxt = pie_pkg::ST_OVER;
        end else begin
          mem_we = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      acc_nxt = '0;
      innum_nxt = 1'b0;
    end
    if (cmd.exec && err_r == pie_pkg::ST_OK) begin
      if (!sts.ge2) err_nxt = pie_pkg::ST_UNDER;
      else if (op_code == pie_pkg::OP_DIV && r_r == 32'd0) err_nxt = pie_pkg::ST_DIVZ;
    end
    if (cmd.wr_res) begin
      mem_we = 1'b1;
      mem_wa = AW'(cnt_r - CW'(2));
      mem_wd = alu;
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.report) begin
      cnt_nxt = '0; acc_nxt = '0; innum_nxt = 1'b0; err_nxt = pie_pkg::ST_OK;
    end
  end

  // Read address: first the right operand (top), then the left.
  assign rd_en  = cmd.rd_ops || cmd.rd_top || rd_sel_r;
  assign mem_ra = rd_sel_r ? AW'(cnt_r - CW'(2)) : AW'(cnt_r - CW'(1));

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_r <= mem[mem_ra];
  end

  // Operand capture and ALU.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; acc_r <= '0; innum_r <= 1'b0; err_r <= pie_pkg::ST_OK;
      rd_sel_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; acc_r <= acc_nxt; innum_r <= innum_nxt; err_r <= err_nxt;
      rd_sel_r <= cmd.rd_ops;
    end
    if (cmd.capture) begin
      ch_r <= in_ch;
      last_r <= in_last;
    end
    if (rd_sel_r) r_r <= rd_r;
    if (cmd.exec) l_r <= rd_r;
    prod_r <= l_r * r_r;
    if (cmd.report) begin
      res_value  <= (err_r == pie_pkg::ST_OK && cnt_r != '0) ? rd_r : 32'd0;
      res_status <= (err_r != pie_pkg::ST_OK) ? err_r :
                    (cnt_r == '0) ? pie_pkg::ST_UNDER : pie_pkg::ST_OK;
    end
  end

  // Result select; all sources are settled by the write-back cycle.
  always_comb begin
    case (op_code)
      pie_pkg::OP_ADD: alu = l_r + r_r;
      pie_pkg::OP_SUB: alu = l_r - r_r;
      pie_pkg::OP_MUL: alu = prod_r;
      default:         alu = div_q;
    endcase
  end

  assign div_start = cmd.exec && (op_code == pie_pkg::OP_DIV);

  // Divider takes the left operand straight from the read register.
  pie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(rd_r), .den(r_r),
    .done(div_done), .quo(div_q)
  );
endmodule

/* src/pie_ctrl.sv */
// Evaluator controller: sequences one character through the datapath.
// Depends on pie_pkg.
module pie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output pie_pkg::pie_cmd_t cmd,
  input  pie_pkg::pie_sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RD0 = 4'd2, S_RD1 = 4'd3,
                         S_EXEC = 4'd4, S_MUL = 4'd5, S_DIVW = 4'd6, S_WR = 4'd7,
                         S_FLUSH = 4'd8, S_TOP0 = 4'd9, S_TOP1 = 4'd10, S_REP = 4'd11,
                         S_MUL2 = 4'd12;
  logic [3:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;

  // Next state and commands.
  always_comb begin
    st_nxt = st_r; ov_nxt = ov_r; cmd = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    in_tready = (st_r == S_IDLE);
    unique case (st_r)
      S_IDLE: if (in_tvalid) begin
        cmd.capture = 1'b1;
        st_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.is_digit) begin
          cmd.digit = 1'b1;
          st_nxt = sts.last ? S_FLUSH : S_IDLE;
        end else begin
          cmd.flush = 1'b1;
          st_nxt = (sts.is_op && !sts.err) ? S_RD0 : (sts.last ? S_TOP0 : S_IDLE);
        end
      end
      S_RD0: begin
        cmd.rd_ops = 1'b1;
        st_nxt = S_RD1;
      end
      S_RD1: st_nxt = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.err || !sts.ge2 || (sts.op == pie_pkg::OP_DIV && sts.rzero))
          st_nxt = sts.last ? S_TOP0 : S_IDLE;
        else if (sts.op == pie_pkg::OP_DIV) st_nxt = S_DIVW;
        else if (sts.op == pie_pkg::OP_MUL) st_nxt = S_MUL;
        else st_nxt = S_WR;
      end
      S_MUL: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_WR;
      S_DIVW: if (sts.div_done) st_nxt = S_WR;
      S_WR: begin
        cmd.wr_res = 1'b1;
        st_nxt = sts.last ? S_TOP0 : S_IDLE;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        st_nxt = S_TOP0;
      end
      S_TOP0: begin
        cmd.rd_top = 1'b1;
        st_nxt = S_TOP1;
      end
      S_TOP1: if (!ov_r || out_tready) st_nxt = S_REP;
      S_REP: begin
        cmd.report = 1'b1;
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;
endmodule

/* src/postfix_integer_evaluator_chk.sv */
// Port-level checker for the postfix integer evaluator, bound to the top level.
// Depends on postfix_integer_evaluator_assert.svh.
`include "postfix_integer_evaluator_assert.svh"
module postfix_integer_evaluator_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  // A result held back by the sink keeps its value.
  `PIE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "out held")
  // Padding bits are always zero.
  `PIE_ASSERT_IMP(a_pad, clk, rst_n, out_tvalid, out_tdata[39:34] == 6'd0, "pad set")
  // A non-ok report carries a zero value.
  `PIE_ASSERT_IMP(a_err_val, clk, rst_n, out_tvalid && out_tdata[33:32] != 2'd0,
                  out_tdata[31:0] == 32'd0, "error value")
  // A request without tlast never produces a report in the next cycle.
  `PIE_ASSERT_NXT(a_no_rep, clk, rst_n, in_tvalid && in_tready && !in_tlast && !out_tvalid,
                  !out_tvalid, "spurious report")
endmodule

bind postfix_integer_evaluator postfix_integer_evaluator_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

/* dv/testbench.sv */
// Self-checking testbench for the postfix integer evaluator.
// Depends on pie_pkg and postfix_integer_evaluator; predicts each report and compares it.
`timescale 1ns / 100ps

module testbench;
  localparam int DEPTH = pie_pkg::STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  postfix_integer_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } report_t;

  // Predictor state, mirrors the block's expression state.
  logic [31:0] eval_stack [DEPTH];
  int          eval_count;
  logic [31:0] eval_accum;
  bit          eval_in_num;
  logic [1:0]  eval_err;

  report_t expected_reports[$];
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_cycles;
  int      fail_count;
  int      report_count;
  int      char_count;
  longint  cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void note_error(logic [1:0] code);
    if (eval_err == pie_pkg::ST_OK) eval_err = code;
  endfunction

  function automatic void push_operand(logic [31:0] v);
    if (eval_count >= DEPTH) begin
      note_error(pie_pkg::ST_OVER);
    end else begin
      eval_stack[eval_count] = v;
      eval_count++;
    end
  endfunction

  function automatic void close_number();
    if (eval_in_num) begin
      if (eval_err == pie_pkg::ST_OK) push_operand(eval_accum);
      eval_accum = '0;
      eval_in_num = 0;
    end
  endfunction

  function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic void apply_operator(logic [7:0] c);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] res;
    if (eval_count < 2) begin
      note_error(pie_pkg::ST_UNDER);
      return;
    end
    r = eval_stack[eval_count - 1];
    l = eval_stack[eval_count - 2];
    if (c == pie_pkg::CH_DIV && r == 0) begin
      note_error(pie_pkg::ST_DIVZ);
      return;
    end
    case (c)
      pie_pkg::CH_ADD: res = l + r;
      pie_pkg::CH_SUB: res = l - r;
      pie_pkg::CH_MUL: res = l * r;
      default: res = signed_quotient(l, r);
    endcase
    eval_count -= 2;
    eval_stack[eval_count] = res;
    eval_count++;
  endfunction

  // Advance the predictor by one accepted character.
  function automatic void predict_char(logic [7:0] c, bit last);
    report_t rep;
    if (c >= pie_pkg::CH_ZERO && c <= pie_pkg::CH_NINE) begin
      if (eval_err == pie_pkg::ST_OK) begin
        eval_accum = eval_accum * 10 + 32'(c - pie_pkg::CH_ZERO);
        eval_in_num = 1;
      end
    end else begin
      close_number();
      if (eval_err == pie_pkg::ST_OK &&
          (c == pie_pkg::CH_ADD || c == pie_pkg::CH_SUB ||
           c == pie_pkg::CH_MUL || c == pie_pkg::CH_DIV))
        apply_operator(c);
    end
    if (!last) return;
    close_number();
    rep.value = '0;
    if (eval_err != pie_pkg::ST_OK) begin
      rep.status = eval_err;
    end else if (eval_count == 0) begin
      rep.status = pie_pkg::ST_UNDER;
    end else begin
      rep.value = eval_stack[eval_count - 1];
      rep.status = pie_pkg::ST_OK;
    end
    expected_reports.push_back(rep);
    eval_count = 0;
    eval_accum = '0;
    eval_in_num = 0;
    eval_err = pie_pkg::ST_OK;
  endfunction

  // Offer one character and wait for the request to be taken.
  // Valid drops only while the sender idles, so back-to-back requests keep it high.
  task automatic send_char(logic [7:0] c, bit last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_char(c, last);
    char_count++;
  endtask

  task automatic send_string(string s, bit end_expr = 1);
    for (int i = 0; i < s.len(); i++) send_char(s[i], end_expr && i == s.len() - 1);
  endtask

  task automatic send_number(logic [31:0] v);
    string s;
    s = $sformatf("%0d", v);
    send_string(s, 0);
  endtask

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted report with the oldest prediction.
  always @(posedge clk) begin
    report_t exp_rep;
    if (rst_n && out_tvalid && out_tready) begin
      report_count++;
      if (expected_reports.size() == 0) begin
        $error("Report with no prediction: value=%0h status=%0d",
               out_tdata[31:0], out_tdata[33:32]);
        fail_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (out_tdata[31:0] !== exp_rep.value) begin
          $error("value: expected %0h, actual %0h", exp_rep.value, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[33:32] !== exp_rep.status) begin
          $error("status: expected %0d, actual %0d", exp_rep.status, out_tdata[33:32]);
          fail_count++;
        end
        if (out_tdata[39:34] !== 6'd0) begin
          $error("zero fill: expected 0, actual %0h", out_tdata[39:34]);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Extremes, every operator, skipped characters and the underflow and divide-by-zero cases.
  task automatic test_directed();
    send_string("3 4+");
    send_string("10 3-");
    send_string("7 6*");
    send_string("7 2/");
    send_string("0 7 - 2/");
    send_string("4294967295");
    send_string("99999999999");
    send_string("5+");
    send_string("");
    send_char(" ", 1);
    send_string("1 0/ 5 5 + +");
    send_string("2147483648 1 -");
    send_string("0 2147483648 - 1 - 0 1 - /");
    send_string("65536 65536 *");
    send_string("12a3b+");
    send_char(8'hFF, 0);
    send_char(8'h00, 1);
    send_string("1 2 3");
  endtask

  // Fill the stack past its depth.
  task automatic test_overflow();
    for (int i = 0; i < DEPTH; i++) send_string("1 ", 0);
    send_string("2 3 +");
    for (int i = 0; i < DEPTH; i++) send_string("9 ", 0);
    send_string("+");
  endtask

  // One random well-formed expression, or occasional noise.
  task automatic send_random_expr();
    int depth;
    int n_ops;
    logic [7:0] ops [4];
    ops = '{pie_pkg::CH_ADD, pie_pkg::CH_SUB, pie_pkg::CH_MUL, pie_pkg::CH_DIV};
    if ($urandom_range(9) == 0) begin
      n_ops = $urandom_range(1, 8);
      for (int i = 0; i < n_ops; i++) send_char(8'($urandom), 0);
      send_char(8'($urandom), 1);
      return;
    end
    depth = 0;
    n_ops = $urandom_range(1, 5);
    while (n_ops > 0 || depth > 1) begin
      if (depth < 2 || (n_ops > 0 && $urandom_range(2) == 0 && depth < 6)) begin
        case ($urandom_range(3))
          0: send_number($urandom_range(9));
          1: send_number($urandom);
          default: send_number($urandom_range(1000));
        endcase
        send_char(" ", 0);
        depth++;
        if (n_ops > 0) n_ops--;
      end else begin
        // Division mostly avoided: it is the slow path.
        send_char(($urandom_range(5) == 0) ? pie_pkg::CH_DIV : ops[$urandom_range(2)], 0);
        depth--;
      end
    end
    send_char(($urandom_range(3) == 0) ? ops[$urandom_range(3)] : " ", 1);
  endtask

  task automatic test_random(int chars);
    int target;
    target = char_count + chars;
    while (char_count < target) send_random_expr();
  endtask

  // Receiver holds off while characters keep coming.
  task automatic test_back_pressure();
    hold_off_cycles = 3000;
    test_random(150);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    fail_count = 0;
    report_count = 0;
    char_count = 0;
    cycle_count = 0;
    eval_count = 0;
    eval_accum = '0;
    eval_in_num = 0;
    eval_err = pie_pkg::ST_OK;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random(200);
    send_idle_pct = 53;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    test_random(400);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_back_pressure();
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Sent %0d characters and checked %0d reports, covering all operators,",
             char_count, report_count);
    $display("error cases, stack overflow, idle and stall phases and a long hold-off.");
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
